// ----- rtl/core/cfba_pkg.sv -----
package cfba_pkg;

  localparam int unsigned CACHE_ENTRIES_DEF = 100;
  localparam int unsigned MAX_BLOCKS_DEF    = 4096;

  localparam int unsigned BLK_W = 12;
  localparam int unsigned CFG_W = 13;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_INVALID = 2'd2
  } cfba_status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } cfba_req_e;

  typedef struct packed {
    logic               req_type;
    logic [BLK_W-1:0]   block_in;
  } cfba_req_t;

  typedef struct packed {
    logic [BLK_W-1:0]   block_out;
    cfba_status_e       status;
  } cfba_rsp_t;

endpackage

// ----- rtl/core/chained_free_block_allocator.sv -----
// Chained free-block allocator with a cache of free block numbers.
//
// Command channel: drive req_i and raise start; the transaction is taken on
// a rising edge where start is high and busy is low. req_type 0 allocates a
// block, 1 frees req_i.block_in. Each transaction gives exactly one result:
// done_o pulses for one cycle with rsp_o (block_out, status). The receiver
// cannot stall, so sample rsp_o whenever done_o is high.
//
// A free on an empty cache first writes back the end marker, then pushes. A
// free on a full cache spills the cache into the chain record of the freed
// block; an alloc that empties the cache refills it from the chain record.
// Both copies stream one word per cycle through one shared index counter and
// address incrementer. busy stays high for the whole transaction and drops
// with done_o, so the next transaction can be taken on the edge that samples
// the result.
//
// Configuration: cfg_we_i writes fs_size from cfg_wdata_i; write it only
// while idle. Reset clears fs_size, sets the cache count to 1 with entry 0
// reading as the end marker; the chain memory is not cleared.
module chained_free_block_allocator #(
  parameter int unsigned CACHE_ENTRIES = cfba_pkg::CACHE_ENTRIES_DEF,
  parameter int unsigned MAX_BLOCKS    = cfba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  cfba_pkg::cfba_req_t        req_i,
  output logic                       done_o,
  output cfba_pkg::cfba_rsp_t        rsp_o,
  input  logic                       cfg_we_i,
  input  logic [cfba_pkg::CFG_W-1:0] cfg_wdata_i
);
  import cfba_pkg::*;

  localparam int unsigned NBLK = (MAX_BLOCKS > 4096) ? 4096 : MAX_BLOCKS;
  localparam int unsigned CAW  = $clog2(CACHE_ENTRIES);
  localparam int unsigned CHW  = $clog2(NBLK * (CACHE_ENTRIES + 1));

  // Cache port
  logic             cache_we;
  logic             cache_re;
  logic [CAW-1:0]   cache_addr;
  logic [BLK_W-1:0] cache_wdata;
  logic [BLK_W-1:0] cache_rdata;

  // Chain record port
  logic             chain_we;
  logic             chain_re;
  logic [CHW-1:0]   chain_addr;
  logic [BLK_W-1:0] chain_wdata;
  logic [BLK_W-1:0] chain_rdata;

  // Sequencer: decodes the transaction, owns the count, the fs_size register,
  // the copy counter and the chain address that walk the memories during spill and refill.
  cfba_ctrl #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .MAX_BLOCKS    (MAX_BLOCKS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .done_o        (done_o),
    .rsp_o         (rsp_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cache_we_o    (cache_we),
    .cache_re_o    (cache_re),
    .cache_addr_o  (cache_addr),
    .cache_wdata_o (cache_wdata),
    .cache_rdata_i (cache_rdata),
    .chain_we_o    (chain_we),
    .chain_re_o    (chain_re),
    .chain_addr_o  (chain_addr),
    .chain_wdata_o (chain_wdata),
    .chain_rdata_i (chain_rdata)
  );

  // Free-block cache, registered read.
  cfba_cache #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_cache (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cache_we),
    .re_i    (cache_re),
    .addr_i  (cache_addr),
    .wdata_i (cache_wdata),
    .rdata_o (cache_rdata)
  );

  // Chain records, one per block, registered read.
  cfba_chain #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .MAX_BLOCKS    (MAX_BLOCKS)
  ) u_chain (
    .clk_i   (clk_i),
    .we_i    (chain_we),
    .re_i    (chain_re),
    .addr_i  (chain_addr),
    .wdata_i (chain_wdata),
    .rdata_o (chain_rdata)
  );

endmodule

// ----- rtl/core/cfba_cache.sv -----
module cfba_cache #(
  parameter int unsigned CACHE_ENTRIES = cfba_pkg::CACHE_ENTRIES_DEF,
  localparam int unsigned CAW = $clog2(CACHE_ENTRIES)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [CAW-1:0]           addr_i,
  input  logic [cfba_pkg::BLK_W-1:0] wdata_i,
  output logic [cfba_pkg::BLK_W-1:0] rdata_o
);
  import cfba_pkg::*;

  logic [BLK_W-1:0] mem [CACHE_ENTRIES];
  logic [BLK_W-1:0] rdata_q;
  // Entry 0 reads as the end marker until something is written there.
  logic             e0_wr_q;
  logic             rzero_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_wr_q <= 1'b0;
      rzero_q <= 1'b0;
    end else begin
      if (we_i && (addr_i == '0)) begin
        e0_wr_q <= 1'b1;
      end
      if (re_i) begin
        rzero_q <= (addr_i == '0) && !e0_wr_q;
      end
    end
  end

  assign rdata_o = rzero_q ? '0 : rdata_q;

endmodule

// ----- rtl/core/cfba_chain.sv -----
module cfba_chain #(
  parameter int unsigned CACHE_ENTRIES = cfba_pkg::CACHE_ENTRIES_DEF,
  parameter int unsigned MAX_BLOCKS    = cfba_pkg::MAX_BLOCKS_DEF,
  localparam int unsigned NBLK  = (MAX_BLOCKS > 4096) ? 4096 : MAX_BLOCKS,
  localparam int unsigned DEPTH = NBLK * (CACHE_ENTRIES + 1),
  localparam int unsigned CHW   = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic                       re_i,
  input  logic [CHW-1:0]             addr_i,
  input  logic [cfba_pkg::BLK_W-1:0] wdata_i,
  output logic [cfba_pkg::BLK_W-1:0] rdata_o
);
  import cfba_pkg::*;

  // One record per block: word 0 is the spilled count, words 1.. the entries.
  logic [BLK_W-1:0] mem [DEPTH];
  logic [BLK_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/cfba_ctrl.sv -----
module cfba_ctrl #(
  parameter int unsigned CACHE_ENTRIES = cfba_pkg::CACHE_ENTRIES_DEF,
  parameter int unsigned MAX_BLOCKS    = cfba_pkg::MAX_BLOCKS_DEF,
  localparam int unsigned NBLK = (MAX_BLOCKS > 4096) ? 4096 : MAX_BLOCKS,
  localparam int unsigned REC  = CACHE_ENTRIES + 1,
  localparam int unsigned CAW  = $clog2(CACHE_ENTRIES),
  localparam int unsigned CHW  = $clog2(NBLK * REC)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  cfba_pkg::cfba_req_t        req_i,
  output logic                       done_o,
  output cfba_pkg::cfba_rsp_t        rsp_o,
  input  logic                       cfg_we_i,
  input  logic [cfba_pkg::CFG_W-1:0] cfg_wdata_i,
  output logic                       cache_we_o,
  output logic                       cache_re_o,
  output logic [CAW-1:0]             cache_addr_o,
  output logic [cfba_pkg::BLK_W-1:0] cache_wdata_o,
  input  logic [cfba_pkg::BLK_W-1:0] cache_rdata_i,
  output logic                       chain_we_o,
  output logic                       chain_re_o,
  output logic [CHW-1:0]             chain_addr_o,
  output logic [cfba_pkg::BLK_W-1:0] chain_wdata_o,
  input  logic [cfba_pkg::BLK_W-1:0] chain_rdata_i
);
  import cfba_pkg::*;

  localparam int unsigned CNW = $clog2(CACHE_ENTRIES + 1);

  localparam logic [CNW-1:0]   CE_C   = CNW'(CACHE_ENTRIES);
  localparam logic [CNW-1:0]   CE_M1  = CNW'(CACHE_ENTRIES - 1);
  localparam logic [CNW-1:0]   ONE_C  = CNW'(1);
  localparam logic [BLK_W-1:0] CE_W   = BLK_W'(CACHE_ENTRIES);
  localparam logic [CHW-1:0]   REC_C  = CHW'(REC);
  localparam logic [16:0]      MAXB_C = 17'(MAX_BLOCKS);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EXEC    = 4'd1;
  localparam logic [3:0] S_POP     = 4'd2;
  localparam logic [3:0] S_SP_COPY = 4'd3;
  localparam logic [3:0] S_SP_END  = 4'd4;
  localparam logic [3:0] S_RF_HDR  = 4'd5;
  localparam logic [3:0] S_RF_CNT  = 4'd6;
  localparam logic [3:0] S_RF_COPY = 4'd7;

  logic [3:0]       state_q, state_d;
  logic [CNW-1:0]   count_q, count_d;
  logic [CFG_W-1:0] fs_size_q;
  logic             done_q, done_d;
  cfba_rsp_t        rsp_q, rsp_d;

  logic [CNW-1:0]   idx_q, idx_d;
  logic [CHW-1:0]   caddr_q, caddr_d;
  logic [BLK_W-1:0] blk_q, blk_d;
  logic             req_q, req_d;

  logic             blk_bad;
  logic             pop_bad;
  logic [CNW-1:0]   cnt_m1;

  assign blk_bad = (blk_q == '0) || ({1'b0, blk_q} >= fs_size_q)
                || ({5'd0, blk_q} >= MAXB_C);
  assign pop_bad = ({5'd0, cache_rdata_i} >= MAXB_C);
  assign cnt_m1  = count_q - ONE_C;

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    idx_d         = idx_q;
    caddr_d       = caddr_q;
    blk_d         = blk_q;
    req_d         = req_q;
    done_d        = 1'b0;
    rsp_d         = rsp_q;
    cache_we_o    = 1'b0;
    cache_re_o    = 1'b0;
    cache_addr_o  = '0;
    cache_wdata_o = '0;
    chain_we_o    = 1'b0;
    chain_re_o    = 1'b0;
    chain_wdata_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d   = req_i.req_type;
          blk_d   = req_i.block_in;
          caddr_d = CHW'(req_i.block_in) * REC_C;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        if (req_q == REQ_FREE) begin
          if (blk_bad) begin
            state_d         = S_IDLE;
            done_d          = 1'b1;
            rsp_d.block_out = '0;
            rsp_d.status    = ST_INVALID;
          end else if (count_q == '0) begin
            // Put back the end marker, then push on the next pass.
            cache_we_o = 1'b1;
            count_d    = ONE_C;
          end else if (count_q >= CE_C) begin
            // Write the count word and start streaming the cache out.
            chain_we_o    = 1'b1;
            chain_wdata_o = BLK_W'(count_q);
            caddr_d       = caddr_q + CHW'(1);
            cache_re_o    = 1'b1;
            idx_d         = ONE_C;
            state_d       = S_SP_COPY;
          end else begin
            cache_we_o      = 1'b1;
            cache_addr_o    = count_q[CAW-1:0];
            cache_wdata_o   = blk_q;
            count_d         = count_q + ONE_C;
            state_d         = S_IDLE;
            done_d          = 1'b1;
            rsp_d.block_out = '0;
            rsp_d.status    = ST_OK;
          end
        end else begin
          if (count_q == '0) begin
            state_d         = S_IDLE;
            done_d          = 1'b1;
            rsp_d.block_out = '0;
            rsp_d.status    = ST_NOSPACE;
          end else begin
            cache_re_o   = 1'b1;
            cache_addr_o = cnt_m1[CAW-1:0];
            count_d      = cnt_m1;
            state_d      = S_POP;
          end
        end
      end

      S_POP: begin
        if (cache_rdata_i == '0) begin
          count_d         = '0;
          state_d         = S_IDLE;
          done_d          = 1'b1;
          rsp_d.block_out = '0;
          rsp_d.status    = ST_NOSPACE;
        end else if ((count_q == '0) && !pop_bad) begin
          blk_d   = cache_rdata_i;
          caddr_d = CHW'(cache_rdata_i) * REC_C;
          state_d = S_RF_HDR;
        end else begin
          state_d         = S_IDLE;
          done_d          = 1'b1;
          rsp_d.block_out = cache_rdata_i;
          rsp_d.status    = ST_OK;
        end
      end

      S_SP_COPY: begin
        chain_we_o    = 1'b1;
        chain_wdata_o = cache_rdata_i;
        caddr_d       = caddr_q + CHW'(1);
        if (idx_q != CE_C) begin
          cache_re_o   = 1'b1;
          cache_addr_o = idx_q[CAW-1:0];
          idx_d        = idx_q + ONE_C;
        end else begin
          state_d = S_SP_END;
        end
      end

      S_SP_END: begin
        cache_we_o      = 1'b1;
        cache_wdata_o   = blk_q;
        count_d         = ONE_C;
        state_d         = S_IDLE;
        done_d          = 1'b1;
        rsp_d.block_out = '0;
        rsp_d.status    = ST_OK;
      end

      S_RF_HDR: begin
        chain_re_o = 1'b1;
        caddr_d    = caddr_q + CHW'(1);
        state_d    = S_RF_CNT;
      end

      S_RF_CNT: begin
        count_d    = (chain_rdata_i > CE_W) ? CE_C : chain_rdata_i[CNW-1:0];
        chain_re_o = 1'b1;
        caddr_d    = caddr_q + CHW'(1);
        idx_d      = '0;
        state_d    = S_RF_COPY;
      end

      S_RF_COPY: begin
        cache_we_o    = 1'b1;
        cache_addr_o  = idx_q[CAW-1:0];
        cache_wdata_o = chain_rdata_i;
        if (idx_q != CE_M1) begin
          chain_re_o = 1'b1;
          caddr_d    = caddr_q + CHW'(1);
          idx_d      = idx_q + ONE_C;
        end else begin
          state_d         = S_IDLE;
          done_d          = 1'b1;
          rsp_d.block_out = blk_q;
          rsp_d.status    = ST_OK;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= ONE_C;
      fs_size_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        fs_size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    caddr_q <= caddr_d;
    blk_q   <= blk_d;
    req_q   <= req_d;
    rsp_q   <= rsp_d;
  end

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign rsp_o        = rsp_q;
  assign chain_addr_o = caddr_q;

endmodule

// ----- rtl/core/cfba_checker.sv -----
module cfba_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input cfba_pkg::cfba_rsp_t rsp_o
);
  import cfba_pkg::*;

  // An accepted transaction keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // A result is shown only once the block is idle again.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // Results never come in adjacent cycles: each needs a fresh transaction.
  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in adjacent cycles");

  // A failed request never hands out a block.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status != ST_OK)) |-> (rsp_o.block_out == '0))
    else $error("nonzero block with error status");

  // Completing a transaction drops busy in the same cycle as the result.
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

endmodule

bind chained_free_block_allocator cfba_checker u_cfba_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

// ----- dv/chained_free_block_allocator_tb.sv -----
module chained_free_block_allocator_tb;
  import cfba_pkg::*;

  localparam int unsigned CACHE_N  = CACHE_ENTRIES_DEF;
  localparam int unsigned BLOCKS_N = MAX_BLOCKS_DEF;
  localparam int unsigned REC_N    = CACHE_N + 1;
  localparam int unsigned RAND_N   = 1450;

  // Scheduled activity for the driver: a request, a write of fs_size, or a
  // pause that holds the request channel until every result is back.
  typedef enum logic [1:0] {
    ACT_REQ,
    ACT_CFG,
    ACT_DRAIN
  } action_e;

  typedef struct {
    action_e          kind;
    cfba_req_t        req;
    logic [CFG_W-1:0] cfg;
    int unsigned      gap;
  } action_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  cfba_req_t        req_i       = '0;
  logic             cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             busy;
  logic             done_o;
  cfba_rsp_t        rsp_o;

  action_t     plan_q[$];
  cfba_rsp_t   rsp_exp_q[$];
  int unsigned hold_cnt = 0;
  int unsigned err_cnt  = 0;

  // Free-list mirror: fs_size, cache count, cache and chain records.
  int unsigned         fs_size_m = 0;
  int unsigned         count_m   = 1;
  bit [BLK_W-1:0]      cache_m [CACHE_N];
  bit [BLK_W-1:0]      chain_m [BLOCKS_N][REC_N];

  // What the run went through, for the closing summary.
  int unsigned n_alloc, n_free, n_spill, n_refill, n_nospace, n_invalid;

  chained_free_block_allocator #(
    .CACHE_ENTRIES (CACHE_N),
    .MAX_BLOCKS    (BLOCKS_N)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Apply one accepted transaction to the free-list mirror and return the
  // result the block owes for it.
  function automatic cfba_rsp_t step_free_list(cfba_req_t r);
    cfba_rsp_t      rsp;
    bit [BLK_W-1:0] blk;
    int unsigned    cnt;
    rsp.block_out = '0;
    rsp.status    = ST_OK;
    if (r.req_type == REQ_FREE) begin
      n_free++;
      if (r.block_in == 0 || 32'(r.block_in) >= fs_size_m) begin
        rsp.status = ST_INVALID;
        n_invalid++;
      end else begin
        // An empty cache gets the end marker back before the push.
        if (count_m == 0) begin
          cache_m[0] = '0;
          count_m    = 1;
        end
        if (count_m >= CACHE_N) begin
          // Full cache: spill it into the freed block's chain record and
          // restart the cache with that block alone.
          chain_m[r.block_in][0] = count_m[BLK_W-1:0];
          for (int i = 0; i < CACHE_N; i++) chain_m[r.block_in][i+1] = cache_m[i];
          cache_m[0] = r.block_in;
          count_m    = 1;
          n_spill++;
        end else begin
          cache_m[count_m] = r.block_in;
          count_m++;
        end
      end
    end else begin
      n_alloc++;
      if (count_m == 0) begin
        rsp.status = ST_NOSPACE;
        n_nospace++;
      end else begin
        count_m--;
        blk = cache_m[count_m];
        if (blk == 0) begin
          // End marker popped: the list is exhausted.
          count_m    = 0;
          rsp.status = ST_NOSPACE;
          n_nospace++;
        end else begin
          if (count_m == 0) begin
            // Last entry is a chain block: refill from its record and hand
            // the chain block itself out.
            cnt = 32'(chain_m[blk][0]);
            if (cnt > CACHE_N) cnt = CACHE_N;
            for (int i = 0; i < CACHE_N; i++) cache_m[i] = chain_m[blk][i+1];
            count_m = cnt;
            n_refill++;
          end
          rsp.block_out = blk;
        end
      end
    end
    return rsp;
  endfunction

  // ---------------------------------------------------------------------
  // Plan building
  // ---------------------------------------------------------------------
  task automatic plan_req(input cfba_req_e kind, input int unsigned blk,
                          input int unsigned gap);
    action_t a;
    a.kind             = ACT_REQ;
    a.req.req_type     = kind;
    a.req.block_in     = blk[BLK_W-1:0];
    a.cfg              = '0;
    a.gap              = gap;
    plan_q.push_back(a);
  endtask

  task automatic plan_cfg(input int unsigned value);
    action_t a;
    a.kind = ACT_CFG;
    a.req  = '0;
    a.cfg  = value[CFG_W-1:0];
    a.gap  = 0;
    plan_q.push_back(a);
  endtask

  task automatic plan_drain();
    action_t a;
    a.kind = ACT_DRAIN;
    a.req  = '0;
    a.cfg  = '0;
    a.gap  = 0;
    plan_q.push_back(a);
  endtask

  // Idle style per burst: none, full range, short, or rare long pauses.
  function automatic int unsigned draw_gap(input int unsigned style);
    case (style)
      0:       return 0;
      1:       return $urandom_range(0, 15);
      2:       return $urandom_range(0, 3);
      default: return ($urandom_range(0, 7) == 0) ? 15 : 0;
    endcase
  endfunction

  // Mostly a legal block for the current size, now and then a rejected one.
  function automatic int unsigned pick_block(input int unsigned fs);
    if (fs >= 2 && $urandom_range(0, 19) != 0) return $urandom_range(1, fs - 1);
    if (fs <= BLOCKS_N - 1 && $urandom_range(0, 1) == 1)
      return $urandom_range(fs, BLOCKS_N - 1);
    return 0;
  endfunction

  // kind 0: free run, 1: alloc run, other: random mix.
  task automatic plan_burst(input int unsigned kind, input int unsigned len,
                            input int unsigned fs);
    int unsigned style;
    style = $urandom_range(0, 3);
    for (int unsigned j = 0; j < len; j++) begin
      case (kind)
        0: plan_req(REQ_FREE, pick_block(fs), draw_gap(style));
        1: plan_req(REQ_ALLOC, $urandom_range(0, BLOCKS_N - 1), draw_gap(style));
        default: plan_req(cfba_req_e'($urandom_range(0, 1)),
                          $urandom_range(0, BLOCKS_N - 1), draw_gap(style));
      endcase
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: advance through the plan, one transaction at a time.
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start       <= 1'b0;
      req_i       <= '0;
      cfg_we_i    <= 1'b0;
      cfg_wdata_i <= '0;
      hold_cnt    <= 0;
    end else begin : drive
      logic             nxt_start;
      logic             nxt_we;
      cfba_req_t        nxt_req;
      logic [CFG_W-1:0] nxt_wdata;
      bit               quiet;
      nxt_start = start;
      nxt_req   = req_i;
      nxt_we    = 1'b0;
      nxt_wdata = cfg_wdata_i;
      // The block takes the register write on this edge.
      if (cfg_we_i) fs_size_m = 32'(cfg_wdata_i);
      // Transaction accepted: record what it must produce.
      if (start && !busy) begin
        rsp_exp_q.push_back(step_free_list(req_i));
        nxt_start = 1'b0;
      end
      // Idle means no result owed, none on the wire and the block not busy.
      quiet = (rsp_exp_q.size() == 0) && !done_o && !busy;
      if (!nxt_start && plan_q.size() > 0) begin
        case (plan_q[0].kind)
          ACT_REQ: begin
            if (hold_cnt >= plan_q[0].gap) begin
              nxt_start = 1'b1;
              nxt_req   = plan_q[0].req;
              void'(plan_q.pop_front());
              hold_cnt <= 0;
            end else begin
              hold_cnt <= hold_cnt + 1;
            end
          end
          ACT_CFG: begin
            if (quiet) begin
              nxt_we    = 1'b1;
              nxt_wdata = plan_q[0].cfg;
              void'(plan_q.pop_front());
            end
          end
          default: begin
            if (quiet) void'(plan_q.pop_front());
          end
        endcase
      end
      start       <= nxt_start;
      req_i       <= nxt_req;
      cfg_we_i    <= nxt_we;
      cfg_wdata_i <= nxt_wdata;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every done_o pulse is one result, checked against the oldest
  // expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin : check
      cfba_rsp_t want;
      if (rsp_exp_q.size() == 0) begin
        report_error($sformatf("unexpected result: block %0d status %0d",
                               rsp_o.block_out, rsp_o.status));
      end else begin
        want = rsp_exp_q.pop_front();
        if (rsp_o.block_out !== want.block_out)
          report_error($sformatf("block_out %0d, expected %0d",
                                 rsp_o.block_out, want.block_out));
        if (rsp_o.status !== want.status)
          report_error($sformatf("status %0d, expected %0d",
                                 rsp_o.status, want.status));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    int unsigned n_rand;
    int          phase_left;
    int unsigned gen_fs;
    int unsigned sel;
    int unsigned len;
    int unsigned burst_kind;
    int unsigned waited;

    // Reset value of fs_size is 0: every free is rejected. The reset cache
    // holds only the end marker, so the first alloc pops it and the second
    // finds the cache empty.
    plan_req(REQ_FREE, 1, 0);
    plan_req(REQ_FREE, BLOCKS_N - 1, 0);
    plan_req(REQ_ALLOC, 0, 0);
    plan_req(REQ_ALLOC, BLOCKS_N - 1, 2);
    // Smallest sizes: with 1 nothing is valid, with 2 only block 1.
    plan_cfg(1);
    plan_req(REQ_FREE, 1, 0);
    plan_cfg(2);
    plan_req(REQ_FREE, 2, 1);
    plan_req(REQ_FREE, 1, 0);    // free on an empty cache
    plan_req(REQ_ALLOC, 0, 0);
    plan_req(REQ_ALLOC, 0, 3);   // end marker again
    // Largest size: block 0 rejected, top block legal, alternating bits.
    plan_cfg(BLOCKS_N);
    plan_req(REQ_FREE, 0, 0);
    plan_req(REQ_FREE, BLOCKS_N - 1, 0);
    plan_req(REQ_FREE, 12'hAAA, 0);
    plan_req(REQ_FREE, 12'h555, 5);
    plan_req(REQ_ALLOC, 12'hFFF, 0);
    plan_req(REQ_ALLOC, 0, 0);
    plan_req(REQ_FREE, BLOCKS_N - 1, 0);  // same block twice in the cache
    plan_req(REQ_ALLOC, 0, 0);
    plan_req(REQ_ALLOC, 0, 1);
    plan_req(REQ_ALLOC, 0, 0);
    plan_req(REQ_ALLOC, 0, 0);

    // Random part. Start with a long free run so the chain is several
    // records deep, then drain it through the refills.
    plan_drain();
    gen_fs = BLOCKS_N;
    plan_burst(0, 260, gen_fs);
    plan_burst(1, 270, gen_fs);
    n_rand     = 530;
    phase_left = 100;
    while (n_rand < RAND_N) begin
      if (phase_left <= 0) begin
        // New fs_size setting, extremes included; tiny sizes stay brief.
        sel = $urandom_range(0, 9);
        case (sel)
          0, 1, 2: gen_fs = sel;
          3:       gen_fs = $urandom_range(3, 15);
          4, 5, 6: gen_fs = BLOCKS_N;
          default: gen_fs = $urandom_range(16, BLOCKS_N - 1);
        endcase
        plan_cfg(gen_fs);
        phase_left = (gen_fs < 16) ? $urandom_range(60, 120) : $urandom_range(200, 400);
      end
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1, 2, 3: begin
          burst_kind = 0;
          len        = $urandom_range(60, 260);
        end
        4, 5, 6: begin
          burst_kind = 1;
          len        = $urandom_range(40, 260);
        end
        7, 8: begin
          burst_kind = 2;
          len        = $urandom_range(10, 40);
        end
        default: begin
          plan_drain();
          burst_kind = 2;
          len        = $urandom_range(5, 20);
        end
      endcase
      // Keep the total close to the item budget.
      if (len > RAND_N - n_rand) len = RAND_N - n_rand;
      plan_burst(burst_kind, len, gen_fs);
      n_rand     += len;
      phase_left -= len;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the plan to go out, then for the last result (a refill is
    // the slowest transaction), then a tail to catch stray pulses.
    while (plan_q.size() != 0 || start) @(posedge clk_i);
    waited = 0;
    while (rsp_exp_q.size() != 0 && waited < 4 * CACHE_N) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (CACHE_N + 20) @(posedge clk_i);
    foreach (rsp_exp_q[i])
      report_error($sformatf("result never came: block %0d status %0d",
                             rsp_exp_q[i].block_out, rsp_exp_q[i].status));

    $display("Covered %0d allocs with %0d chain refills and %0d out-of-space results,",
             n_alloc, n_refill, n_nospace);
    $display("and %0d frees with %0d cache spills and %0d rejected blocks.",
             n_free, n_spill, n_invalid);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hang guard, well above the slowest legal run.
  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding", rsp_exp_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
